// ----- sv/rpn_pkg.sv -----
// rpn_pkg: command codes, status codes and the controller-to-datapath command struct
// shared by rpn_ctrl, rpn_dp and rpn_stack_calculator_core; no dependencies
package rpn_pkg;

    localparam int DataW = 64;
    localparam int FracW = 32;
    localparam int LevelW = 8;

    typedef enum logic [3:0] {
        CMD_PUSH  = 4'd0,
        CMD_ADD   = 4'd1,
        CMD_SUB   = 4'd2,
        CMD_MUL   = 4'd3,
        CMD_DIV   = 4'd4,
        CMD_REM   = 4'd5,
        CMD_PRINT = 4'd6,
        CMD_DUP   = 4'd7,
        CMD_SWAP  = 4'd8,
        CMD_CLEAR = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ZDIV  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // datapath operation selected by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_RD_X,      // pop top into x
        OP_RD_Y,      // pop top into y
        OP_PUSH_IN,   // push input value
        OP_PUSH_X,    // push x
        OP_PUSH_Y,    // push y
        OP_PUSH_RES,  // push arithmetic result
        OP_ALU,       // start/step arithmetic
        OP_CLEAR,     // empty the stack
        OP_RD_TOP     // read top for shown value
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;   // first cycle of an operation
    } t_dp_cmd;

    typedef struct packed {
        logic ram_ok;    // read data valid (set in the cycle after a read)
        logic alu_done;
        logic x_zero;
        logic empty;     // stack pointer is zero
        logic full;      // stack pointer is at depth
    } t_dp_sts;

endpackage

// ----- sv/rpn_stack_calculator_core.sv -----
// rpn_stack_calculator_core: top level of the reverse-Polish calculator
// instantiates rpn_ctrl and rpn_dp; uses rpn_pkg
//
// one command item in, one result item out. multiply forms four 32x32 partial
// products on one multiplier, remainder takes 64 steps of the shared divider and
// divide one quotient bit a cycle over 96 steps. the stack lives in a
// single-port-write, registered-read memory of STACK_DEPTH entries; its contents
// are undefined until pushed. a result waits in the output register until taken;
// the sequencer holds its final state while that register is still full, so the
// next command is taken only after the previous result has been handed over to it.
module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [3:0] req_type, [67:4] operand_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // [63:0] shown_value, [71:64] stack_level,
                                        // [73:72] status_code
);
    rpn_pkg::t_dp_cmd  dp_cmd;
    rpn_pkg::t_dp_sts  dp_sts;
    rpn_pkg::t_status  status;
    logic [63:0]       top, x;
    logic [7:0]        level;
    logic              done, printed, out_free;
    logic [3:0]        r_kind;
    logic [63:0]       r_value;
    logic              r_ovalid;
    logic [79:0]       r_odata;

    // command and operand held for the whole item
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind  <= s_axis_tdata[3:0];
            r_value <= s_axis_tdata[67:4];
        end
    end

    rpn_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(rpn_pkg::t_cmd'(s_axis_tready ? s_axis_tdata[3:0] : r_kind)),
        .o_cmd(dp_cmd), .i_sts(dp_sts),
        .o_done(done), .o_printed(printed), .o_status(status),
        .i_out_free(out_free)
    );

    rpn_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(dp_cmd), .i_kind(rpn_pkg::t_cmd'(r_kind)), .i_value(r_value),
        .o_sts(dp_sts), .o_top(top), .o_x(x), .o_level(level)
    );

    // output register
    assign out_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (done && out_free) begin
                r_ovalid <= 1'b1;
                r_odata <= {6'd0, status, level,
                            printed ? x : (dp_sts.ram_ok ? top : 64'd0)};
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule

// ----- sv/rpn_dp.sv -----
// rpn_dp: stack memory, stack pointer, x/y operand registers and the arithmetic units
// (saturating add/sub, partial-product multiply, bit-serial divide); uses rpn_pkg
module rpn_dp #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rpn_pkg::t_dp_cmd             i_cmd,
    input  rpn_pkg::t_cmd                i_kind,
    input  logic [rpn_pkg::DataW-1:0]    i_value,
    output rpn_pkg::t_dp_sts             o_sts,
    output logic [rpn_pkg::DataW-1:0]    o_top,
    output logic [rpn_pkg::DataW-1:0]    o_x,
    output logic [rpn_pkg::LevelW-1:0]   o_level
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int DW = rpn_pkg::DataW;
    localparam int LevelW = rpn_pkg::LevelW;
    localparam logic [DW-1:0] SignBit = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MaxPos  = {1'b0, {(DW-1){1'b1}}};

    logic [DW-1:0] r_mem [STACK_DEPTH];
    logic [DW-1:0] r_rd;
    logic          r_rd_v;
    logic [PW-1:0] r_sp;
    logic [DW-1:0] r_x, r_y, r_res;

    // multiply/divide state
    logic [6:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW-1:0] r_ma, r_mb;
    logic          r_neg;
    logic [127:0]  r_acc;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_q;
    logic          r_big;

    logic          wr_en;
    logic [DW-1:0] wr_data;
    logic          rd_start;
    logic          rd_en;
    logic [DW-1:0] add_r, sub_r, n_rem_sh, ma_y, mb_x;
    logic [DW:0]   rem_sh;
    logic [65:0]   pp;

    assign ma_y = r_y[DW-1] ? (~r_y + 1'b1) : r_y;
    assign mb_x = r_x[DW-1] ? (~r_x + 1'b1) : r_x;
    assign add_r = r_y + r_x;
    assign sub_r = r_y - r_x;

    function automatic logic [DW-1:0] sat(input logic neg, input logic [DW-1:0] mag,
                                          input logic big);
        if (neg) return (big || mag > SignBit) ? SignBit : (~mag + 1'b1);
        return (big || mag > MaxPos) ? MaxPos : mag;
    endfunction

    always_comb begin
        wr_en = 1'b0;
        wr_data = r_x;
        case (i_cmd.op)
            rpn_pkg::OP_PUSH_IN:  begin wr_en = 1'b1; wr_data = i_value; end
            rpn_pkg::OP_PUSH_X:   begin wr_en = 1'b1; wr_data = r_x; end
            rpn_pkg::OP_PUSH_Y:   begin wr_en = 1'b1; wr_data = r_y; end
            rpn_pkg::OP_PUSH_RES: begin wr_en = 1'b1; wr_data = r_res; end
            default: ;
        endcase
        wr_en = wr_en && (r_sp < PW'(STACK_DEPTH));
        rd_start = (i_cmd.op == rpn_pkg::OP_RD_X || i_cmd.op == rpn_pkg::OP_RD_Y
                    || i_cmd.op == rpn_pkg::OP_RD_TOP) && i_cmd.start;
        rd_en = rd_start && (r_sp != '0);
    end

    // stack memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_sp[AW-1:0]] <= wr_data;
        if (rd_en) r_rd <= r_mem[AW'(r_sp - 1'b1)];
    end

    assign rem_sh = {r_rem[DW-1:0], (r_cnt >= 7'd32) ? r_ma[6'(r_cnt - 7'd32)] : 1'b0};
    assign n_rem_sh = rem_sh[DW-1:0] - r_mb;
    assign pp = 66'(r_ma[32*r_cnt[1]+:32] * r_mb[32*r_cnt[0]+:32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_rd_v <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // read data flag holds until the next read
            if (rd_start) r_rd_v <= rd_en;
            r_done <= 1'b0;
            case (i_cmd.op)
                rpn_pkg::OP_RD_X, rpn_pkg::OP_RD_Y, rpn_pkg::OP_RD_TOP: begin
                    if (i_cmd.start) begin
                        if (i_cmd.op != rpn_pkg::OP_RD_TOP && r_sp != '0) r_sp <= r_sp - 1'b1;
                    end else begin
                        if (i_cmd.op == rpn_pkg::OP_RD_X) r_x <= r_rd_v ? r_rd : '0;
                        if (i_cmd.op == rpn_pkg::OP_RD_Y) r_y <= r_rd_v ? r_rd : '0;
                    end
                end
                rpn_pkg::OP_PUSH_IN, rpn_pkg::OP_PUSH_X, rpn_pkg::OP_PUSH_Y,
                rpn_pkg::OP_PUSH_RES: begin
                    if (wr_en) r_sp <= r_sp + 1'b1;
                end
                rpn_pkg::OP_CLEAR: r_sp <= '0;
                rpn_pkg::OP_ALU: begin
                    if (i_cmd.start) begin
                        r_ma <= ma_y;
                        r_mb <= mb_x;
                        r_neg <= r_y[DW-1] ^ r_x[DW-1];
                        r_acc <= '0;
                        r_rem <= '0;
                        r_q <= '0;
                        r_big <= 1'b0;
                        case (i_kind)
                            rpn_pkg::CMD_ADD: begin
                                r_res <= (r_y[DW-1] == r_x[DW-1] && add_r[DW-1] != r_y[DW-1])
                                         ? (r_y[DW-1] ? SignBit : MaxPos) : add_r;
                                r_done <= 1'b1;
                            end
                            rpn_pkg::CMD_SUB: begin
                                r_res <= (r_y[DW-1] != r_x[DW-1] && sub_r[DW-1] != r_y[DW-1])
                                         ? (r_y[DW-1] ? SignBit : MaxPos) : sub_r;
                                r_done <= 1'b1;
                            end
                            rpn_pkg::CMD_MUL: begin r_busy <= 1'b1; r_cnt <= 7'd0; end
                            default:          begin r_busy <= 1'b1; r_cnt <= 7'd95; end
                        endcase
                    end else if (r_busy) begin
                        if (i_kind == rpn_pkg::CMD_MUL) begin
                            // one 32x32 partial product a cycle
                            r_acc <= r_acc + (128'(pp) << (32 * (r_cnt[1] + r_cnt[0])));
                            r_cnt <= r_cnt + 1'b1;
                            if (r_cnt == 7'd3) begin
                                r_busy <= 1'b0;
                                r_cnt <= 7'd4;
                            end
                        end else begin
                            // restoring divide, one quotient bit a cycle
                            if (r_q[DW-1]) r_big <= 1'b1;
                            if (rem_sh >= {1'b0, r_mb}) begin
                                r_rem <= {1'b0, n_rem_sh};
                                r_q <= {r_q[DW-2:0], 1'b1};
                            end else begin
                                r_rem <= rem_sh;
                                r_q <= {r_q[DW-2:0], 1'b0};
                            end
                            // remainder stops once all dividend bits are in
                            if (r_cnt == 7'd0 || (i_kind == rpn_pkg::CMD_REM && r_cnt == 7'd32))
                                r_busy <= 1'b0;
                            else r_cnt <= r_cnt - 1'b1;
                        end
                    end else begin
                        // result stage
                        case (i_kind)
                            rpn_pkg::CMD_MUL: begin
                                r_res <= sat(r_neg, r_acc[DW+31:32], r_acc[127:96] != '0);
                                r_done <= 1'b1;
                            end
                            rpn_pkg::CMD_DIV: begin
                                r_res <= sat(r_neg, r_q, r_big);
                                r_done <= 1'b1;
                            end
                            rpn_pkg::CMD_REM: begin
                                // |y| mod |x|, sign of the dividend
                                r_res <= r_y[DW-1] ? (~r_rem[DW-1:0] + 1'b1) : r_rem[DW-1:0];
                                r_done <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.ram_ok   = r_rd_v;
    assign o_sts.alu_done = r_done;
    assign o_sts.x_zero   = (r_x == '0);
    assign o_sts.empty    = (r_sp == '0);
    assign o_sts.full     = (r_sp >= PW'(STACK_DEPTH));
    assign o_top   = r_rd;
    assign o_x     = r_x;
    assign o_level = LevelW'(r_sp);
endmodule

// ----- sv/rpn_ctrl.sv -----
// rpn_ctrl: command sequencer for the calculator; drives rpn_dp through t_dp_cmd
// and collects the status flags; uses rpn_pkg
module rpn_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rpn_pkg::t_cmd              i_kind,
    output rpn_pkg::t_dp_cmd           o_cmd,
    input  rpn_pkg::t_dp_sts           i_sts,
    output logic                       o_done,
    output logic                       o_printed,
    output rpn_pkg::t_status           o_status,
    input  logic                       i_out_free
);
    typedef enum logic [3:0] {
        S_IDLE, S_X0, S_X1, S_Y0, S_Y1, S_ALU0, S_ALU, S_PUSH1, S_PUSH2,
        S_TOP0, S_TOP1, S_OUT
    } t_state;

    t_state r_state;
    logic   r_empty, r_full, r_zdiv, r_print;

    always_comb begin
        o_cmd.op = rpn_pkg::OP_NONE;
        o_cmd.start = 1'b0;
        case (r_state)
            S_X0:    begin o_cmd.op = rpn_pkg::OP_RD_X; o_cmd.start = 1'b1; end
            S_X1:    o_cmd.op = rpn_pkg::OP_RD_X;
            S_Y0: begin
                // a zero divisor leaves the dividend on the stack
                if (!((i_kind == rpn_pkg::CMD_DIV || i_kind == rpn_pkg::CMD_REM)
                      && i_sts.x_zero)) begin
                    o_cmd.op = rpn_pkg::OP_RD_Y;
                    o_cmd.start = 1'b1;
                end
            end
            S_Y1:    o_cmd.op = rpn_pkg::OP_RD_Y;
            S_ALU0:  begin o_cmd.op = rpn_pkg::OP_ALU; o_cmd.start = 1'b1; end
            S_ALU:   o_cmd.op = rpn_pkg::OP_ALU;
            S_PUSH1: begin
                case (i_kind)
                    rpn_pkg::CMD_PUSH:                   o_cmd.op = rpn_pkg::OP_PUSH_IN;
                    rpn_pkg::CMD_DUP, rpn_pkg::CMD_SWAP: o_cmd.op = rpn_pkg::OP_PUSH_X;
                    rpn_pkg::CMD_CLEAR:                  o_cmd.op = rpn_pkg::OP_CLEAR;
                    default:                             o_cmd.op = rpn_pkg::OP_PUSH_RES;
                endcase
            end
            S_PUSH2: o_cmd.op = (i_kind == rpn_pkg::CMD_DUP) ? rpn_pkg::OP_PUSH_X
                                                             : rpn_pkg::OP_PUSH_Y;
            S_TOP0:  begin o_cmd.op = rpn_pkg::OP_RD_TOP; o_cmd.start = 1'b1; end
            S_TOP1:  o_cmd.op = rpn_pkg::OP_RD_TOP;
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_OUT);
    assign o_printed = r_print;
    assign o_status = r_zdiv ? rpn_pkg::ST_ZDIV : r_full ? rpn_pkg::ST_FULL
                    : r_empty ? rpn_pkg::ST_EMPTY : rpn_pkg::ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_empty <= 1'b0;
            r_full <= 1'b0;
            r_zdiv <= 1'b0;
            r_print <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_empty <= 1'b0;
                    r_full <= 1'b0;
                    r_zdiv <= 1'b0;
                    r_print <= (i_kind == rpn_pkg::CMD_PRINT);
                    case (i_kind) inside
                        rpn_pkg::CMD_PUSH, rpn_pkg::CMD_CLEAR: r_state <= S_PUSH1;
                        [rpn_pkg::CMD_ADD:rpn_pkg::CMD_SWAP]:  r_state <= S_X0;
                        default:                               r_state <= S_TOP0;
                    endcase
                end
                S_X0: begin
                    if (i_sts.empty) r_empty <= 1'b1;
                    r_state <= S_X1;
                end
                S_X1: begin
                    case (i_kind)
                        rpn_pkg::CMD_PRINT: r_state <= S_OUT;
                        rpn_pkg::CMD_DUP:   r_state <= S_PUSH1;
                        default:            r_state <= S_Y0;
                    endcase
                end
                S_Y0: begin
                    if ((i_kind == rpn_pkg::CMD_DIV || i_kind == rpn_pkg::CMD_REM)
                        && i_sts.x_zero) begin
                        r_zdiv <= 1'b1;
                        r_state <= S_TOP0;
                    end else begin
                        if (i_sts.empty) r_empty <= 1'b1;
                        r_state <= S_Y1;
                    end
                end
                S_Y1:    r_state <= (i_kind == rpn_pkg::CMD_SWAP) ? S_PUSH1 : S_ALU0;
                S_ALU0:  r_state <= S_ALU;
                S_ALU:   if (i_sts.alu_done) r_state <= S_PUSH1;
                S_PUSH1: begin
                    if (i_sts.full && i_kind != rpn_pkg::CMD_CLEAR) r_full <= 1'b1;
                    r_state <= (i_kind == rpn_pkg::CMD_DUP || i_kind == rpn_pkg::CMD_SWAP)
                               ? S_PUSH2 : S_TOP0;
                end
                S_PUSH2: begin
                    if (i_sts.full) r_full <= 1'b1;
                    r_state <= S_TOP0;
                end
                S_TOP0:  r_state <= S_TOP1;
                S_TOP1:  r_state <= S_OUT;
                S_OUT:   if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/rpn_checker.sv -----
// rpn_checker: port-level assertions for rpn_stack_calculator_core, bound to it
// depends only on the top level's ports
module rpn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[79:74] == 6'd0)
        else $error("padding bits set");
endmodule

bind rpn_stack_calculator_core rpn_checker u_rpn_checker (.*);
